// ===== src/apg_pkg.sv =====
// alert pulse pattern generator: shared types, script table and derived constants
// no dependencies; used by every module of the block
package apg_pkg;

    localparam int TIME_WIDTH   = 32;
    localparam int NUM_SOURCES  = 6;
    localparam int SOURCE_WIDTH = 3;
    localparam int SCRIPT_ROWS  = 6;
    localparam int MAX_PULSES   = 6;
    localparam int ROW_WIDTH    = $clog2(SCRIPT_ROWS);
    localparam int PULSE_OFFSET = 100;

    // script rows: led length, vibration length, period, pulse count, pause
    localparam int unsigned LED_LEN [SCRIPT_ROWS] = '{100, 100, 100, 100, 100, 100};
    localparam int unsigned VIB_LEN [SCRIPT_ROWS] = '{200, 100, 240, 240, 180, 180};
    localparam int unsigned PERIOD  [SCRIPT_ROWS] = '{320, 400, 380, 450, 600, 600};
    localparam int unsigned COUNT   [SCRIPT_ROWS] = '{2, 3, 4, 5, 6, 6};
    localparam int unsigned PAUSE   [SCRIPT_ROWS] = '{4000, 4000, 5500, 3500, 1500, 1500};

    // packet length per row
    localparam int unsigned PLEN [SCRIPT_ROWS] = '{
        PERIOD[0] * COUNT[0] + PAUSE[0],
        PERIOD[1] * COUNT[1] + PAUSE[1],
        PERIOD[2] * COUNT[2] + PAUSE[2],
        PERIOD[3] * COUNT[3] + PAUSE[3],
        PERIOD[4] * COUNT[4] + PAUSE[4],
        PERIOD[5] * COUNT[5] + PAUSE[5]
    };

    // bounds of the packet lengths above
    localparam int unsigned PLEN_MIN = 4640;
    localparam int unsigned PLEN_MAX = 7020;

    // remainder width; every window edge also fits in it
    localparam int R_WIDTH = $clog2(PLEN_MAX);

    // reciprocal scaling: PLEN_MIN above 2^12 keeps each reciprocal within TIME_WIDTH bits,
    // and the quotient estimate is at most one short
    localparam int RECIP_SHIFT = TIME_WIDTH + 12;

    localparam longint unsigned RECIP [SCRIPT_ROWS] = '{
        (64'd1 << RECIP_SHIFT) / PLEN[0],
        (64'd1 << RECIP_SHIFT) / PLEN[1],
        (64'd1 << RECIP_SHIFT) / PLEN[2],
        (64'd1 << RECIP_SHIFT) / PLEN[3],
        (64'd1 << RECIP_SHIFT) / PLEN[4],
        (64'd1 << RECIP_SHIFT) / PLEN[5]
    };

    localparam int Q_WIDTH =
        $clog2(((64'd1 << TIME_WIDTH) - 64'd1) / PLEN_MIN + 64'd1);

    typedef struct packed {
        logic [SOURCE_WIDTH-1:0] source;
        logic [31:0]             time_ms;
    } query_t;

    typedef struct packed {
        logic led_on;
        logic vibro_on;
    } result_t;

    typedef struct packed {
        logic v_mul;
        logic v_prod;
        logic v_rem;
        logic v_win;
        logic en_mul;
        logic en_prod;
        logic en_rem;
        logic en_win;
    } pipe_ctl_t;

endpackage

// ===== src/apg_mod.sv =====
// alert pulse pattern generator: time modulo packet length, three register stages
// depends on apg_pkg (script table, reciprocals, pipeline control struct)
module apg_mod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  apg_pkg::pipe_ctl_t             ctl,
    input  apg_pkg::query_t                query,
    output logic [apg_pkg::R_WIDTH-1:0]    rem,
    output logic [apg_pkg::ROW_WIDTH-1:0]  row,
    output logic                           src_ok
);
    import apg_pkg::*;

    localparam int QP_WIDTH = Q_WIDTH + R_WIDTH;

    // stage 1: quotient estimate by reciprocal multiply
    logic                    ok1_next;
    logic [ROW_WIDTH-1:0]    row1_next;
    logic [TIME_WIDTH-1:0]   t1_next;
    logic [TIME_WIDTH-1:0]   recip;
    logic [2*TIME_WIDTH-1:0] prod;
    logic [Q_WIDTH-1:0]      q1_next;

    logic                    ok1_reg;
    logic [ROW_WIDTH-1:0]    row1_reg;
    logic [TIME_WIDTH-1:0]   t1_reg;
    logic [Q_WIDTH-1:0]      q1_reg;

    always_comb
    begin
        ok1_next  = (int'(query.source) < NUM_SOURCES) && (int'(query.source) < SCRIPT_ROWS);
        // unknown sources read row 0 and are masked at the end
        row1_next = ok1_next ? ROW_WIDTH'(query.source) : '0;
        t1_next   = query.time_ms[TIME_WIDTH-1:0];
        recip     = TIME_WIDTH'(RECIP[row1_next]);
        prod      = (2*TIME_WIDTH)'(t1_next) * (2*TIME_WIDTH)'(recip);
        q1_next   = prod[RECIP_SHIFT +: Q_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            ok1_reg  <= ok1_next;
            row1_reg <= row1_next;
            t1_reg   <= t1_next;
            q1_reg   <= q1_next;
        end
    end

    // stage 2: quotient times packet length
    logic [QP_WIDTH-1:0]   qp2_next;
    logic                  ok2_reg;
    logic [ROW_WIDTH-1:0]  row2_reg;
    logic [TIME_WIDTH-1:0] t2_reg;
    logic [QP_WIDTH-1:0]   qp2_reg;

    assign qp2_next = QP_WIDTH'(q1_reg) * QP_WIDTH'(R_WIDTH'(PLEN[row1_reg]));

    always_ff @(posedge clk)
    begin
        if (ctl.en_prod)
        begin
            ok2_reg  <= ok1_reg;
            row2_reg <= row1_reg;
            t2_reg   <= t1_reg;
            qp2_reg  <= qp2_next;
        end
    end

    // stage 3: subtract and one correction step
    logic [TIME_WIDTH-1:0] diff;
    logic [R_WIDTH:0]      rest;
    logic [R_WIDTH:0]      plen3;
    logic [R_WIDTH-1:0]    r3_next;
    logic                  ok3_reg;
    logic [ROW_WIDTH-1:0]  row3_reg;
    logic [R_WIDTH-1:0]    r3_reg;

    always_comb
    begin
        diff  = t2_reg - qp2_reg[TIME_WIDTH-1:0];
        rest  = diff[R_WIDTH:0];
        plen3 = (R_WIDTH+1)'(PLEN[row2_reg]);
        if (rest >= plen3)
            r3_next = R_WIDTH'(rest - plen3);
        else
            r3_next = rest[R_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_rem)
        begin
            ok3_reg  <= ok2_reg;
            row3_reg <= row2_reg;
            r3_reg   <= r3_next;
        end
    end

    assign rem    = r3_reg;
    assign row    = row3_reg;
    assign src_ok = ok3_reg;

    // quotient estimate is never more than one packet short
    a_quot_close: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.v_prod |-> (qp2_reg <= QP_WIDTH'(t2_reg))
                       && (diff < TIME_WIDTH'(2 * PLEN[row2_reg])))
        else $error("apg_mod: quotient estimate out of range");

    a_rem_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.v_rem |-> r3_reg < R_WIDTH'(PLEN[row3_reg]))
        else $error("apg_mod: remainder not below packet length");

endmodule

// ===== src/apg_window.sv =====
// alert pulse pattern generator: pulse window compare and result register
// depends on apg_pkg (script table, result type, pipeline control struct)
module apg_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apg_pkg::pipe_ctl_t            ctl,
    input  logic [apg_pkg::R_WIDTH-1:0]   rem,
    input  logic [apg_pkg::ROW_WIDTH-1:0] row,
    input  logic                          src_ok,
    output apg_pkg::result_t              result
);
    import apg_pkg::*;

    // per row and pulse: window start, inclusive led end, exclusive vibration end
    logic [R_WIDTH-1:0] start_tab   [SCRIPT_ROWS][MAX_PULSES];
    logic [R_WIDTH-1:0] led_end_tab [SCRIPT_ROWS][MAX_PULSES];
    logic [R_WIDTH-1:0] vib_end_tab [SCRIPT_ROWS][MAX_PULSES];
    logic               used_tab    [SCRIPT_ROWS][MAX_PULSES];

    for (genvar g = 0; g < SCRIPT_ROWS; g++)
    begin : g_row
        for (genvar p = 0; p < MAX_PULSES; p++)
        begin : g_pulse
            assign start_tab[g][p]   = R_WIDTH'(PULSE_OFFSET + p * PERIOD[g]);
            assign led_end_tab[g][p] = R_WIDTH'(PULSE_OFFSET + p * PERIOD[g] + LED_LEN[g]);
            assign vib_end_tab[g][p] = R_WIDTH'(PULSE_OFFSET + p * PERIOD[g] + VIB_LEN[g]);
            assign used_tab[g][p]    = (p < COUNT[g]);
        end
    end

    logic [MAX_PULSES-1:0] led_hit;
    logic [MAX_PULSES-1:0] vib_hit;
    result_t               res_next;
    result_t               res_reg;

    always_comb
    begin
        for (int p = 0; p < MAX_PULSES; p++)
        begin
            led_hit[p] = used_tab[row][p] && (rem >= start_tab[row][p])
                         && (rem <= led_end_tab[row][p]);
            vib_hit[p] = used_tab[row][p] && (rem >= start_tab[row][p])
                         && (rem < vib_end_tab[row][p]);
        end
        res_next.led_on   = src_ok && (|led_hit);
        res_next.vibro_on = src_ok && (|vib_hit);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_win)
            res_reg <= res_next;
    end

    assign result = res_reg;

    // a source without a script row gives a dark, still result
    a_bad_source_off: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.v_rem && ctl.en_win && !src_ok) |=> (res_reg == '0))
        else $error("apg_window: unknown source produced an active output");

endmodule

// ===== src/alert_pulse_pattern_gen_unit.sv =====
// Alert pulse pattern generator. Each query item carries a source number and a
// millisecond time; the result item says whether the LED and the vibration motor
// are on at that time under the source's fixed pulse script. One item is taken
// every clock cycle unless the output stalls; each query passes in order through
// a reciprocal multiply, a quotient-times-length multiply, a subtract with one
// correction, then the pulse window compare into the output register. The two
// multipliers set the stage boundaries. A stalled output holds its item while the
// empty stages behind it keep filling, so input is refused only once every stage
// is full. Sources without a script row give both outputs low.
// depends on apg_pkg, apg_mod, apg_window
module alert_pulse_pattern_gen_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_ready,
    input  apg_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_ready,
    output apg_pkg::result_t result
);
    import apg_pkg::*;

    logic v_mul_reg,  v_prod_reg,  v_rem_reg,  v_win_reg;
    logic v_mul_next, v_prod_next, v_rem_next, v_win_next;
    logic en_mul, en_prod, en_rem, en_win;
    pipe_ctl_t ctl;

    logic [R_WIDTH-1:0]   rem;
    logic [ROW_WIDTH-1:0] row;
    logic                 src_ok;

    // a stage loads when empty or when the stage after it moves on
    always_comb
    begin
        en_win  = !v_win_reg  || result_ready;
        en_rem  = !v_rem_reg  || en_win;
        en_prod = !v_prod_reg || en_rem;
        en_mul  = !v_mul_reg  || en_prod;

        v_mul_next  = en_mul  ? query_valid : v_mul_reg;
        v_prod_next = en_prod ? v_mul_reg   : v_prod_reg;
        v_rem_next  = en_rem  ? v_prod_reg  : v_rem_reg;
        v_win_next  = en_win  ? v_rem_reg   : v_win_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mul_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            v_rem_reg  <= 1'b0;
            v_win_reg  <= 1'b0;
        end
        else
        begin
            v_mul_reg  <= v_mul_next;
            v_prod_reg <= v_prod_next;
            v_rem_reg  <= v_rem_next;
            v_win_reg  <= v_win_next;
        end
    end

    always_comb
    begin
        ctl.v_mul   = v_mul_reg;
        ctl.v_prod  = v_prod_reg;
        ctl.v_rem   = v_rem_reg;
        ctl.v_win   = v_win_reg;
        ctl.en_mul  = en_mul;
        ctl.en_prod = en_prod;
        ctl.en_rem  = en_rem;
        ctl.en_win  = en_win;
    end

    assign query_ready  = en_mul;
    assign result_valid = v_win_reg;

    apg_mod u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .query  (query),
        .rem    (rem),
        .row    (row),
        .src_ok (src_ok)
    );

    apg_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rem    (rem),
        .row    (row),
        .src_ok (src_ok),
        .result (result)
    );

    // an item in the last compute stage reaches the output once that stage opens
    a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (v_rem_reg && en_win) |=> result_valid)
        else $error("alert_pulse_pattern_gen_unit: item lost before output register");

endmodule

// ===== test/testbench.sv =====
// testbench for alert_pulse_pattern_gen_unit: drives query items, predicts led and vibration
// results from its own script table and checks each result item in order
// depends on apg_pkg and the block's RTL
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import apg_pkg::*;

    class pulse_scoreboard;
        result_t expected_pulses[$];
        int      mismatches;
        int      failures;

        function new();
            mismatches = 0;
            failures   = 0;
        endfunction

        // fixed script rows: led length, vibration length, period, pulse count, pause
        function automatic bit script_row(input int src, output longint unsigned led_len,
                                          output longint unsigned vib_len,
                                          output longint unsigned period,
                                          output longint unsigned count,
                                          output longint unsigned pause);
            bit found;
            found = 1'b1;
            case (src)
                0: begin led_len = 100; vib_len = 200; period = 320; count = 2; pause = 4000; end
                1: begin led_len = 100; vib_len = 100; period = 400; count = 3; pause = 4000; end
                2: begin led_len = 100; vib_len = 240; period = 380; count = 4; pause = 5500; end
                3: begin led_len = 100; vib_len = 240; period = 450; count = 5; pause = 3500; end
                4, 5:
                begin
                    led_len = 100; vib_len = 180; period = 600; count = 6; pause = 1500;
                end
                default:
                begin
                    led_len = 0; vib_len = 0; period = 0; count = 0; pause = 0;
                    found = 1'b0;
                end
            endcase
            return found;
        endfunction

        function automatic result_t predict_pulses(input query_t q);
            result_t         res;
            longint unsigned led_len, vib_len, period, count, pause;
            longint unsigned plen, r, start;
            res = '0;
            if (script_row(int'(q.source), led_len, vib_len, period, count, pause))
            begin
                plen = period * count + pause;
                if (plen != 0)
                begin
                    r = longint'(q.time_ms) % plen;
                    for (longint unsigned i = 0; i < count; i++)
                    begin
                        start = i * period + 100;
                        // led window closes inclusively, vibration window strictly
                        if (r >= start && r <= start + led_len)
                            res.led_on = 1'b1;
                        if (r >= start && r < start + vib_len)
                            res.vibro_on = 1'b1;
                    end
                end
            end
            return res;
        endfunction

        function void note_query(input query_t q);
            expected_pulses.push_back(predict_pulses(q));
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_pulses.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: led_on=%0b vibro_on=%0b",
                             got.led_on, got.vibro_on);
                return;
            end
            want = expected_pulses.pop_front();
            if (got.led_on !== want.led_on || got.vibro_on !== want.vibro_on)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: led_on exp %0b got %0b, vibro_on exp %0b got %0b",
                             want.led_on, got.led_on, want.vibro_on, got.vibro_on);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    query_valid;
    logic    query_ready;
    query_t  query;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    pulse_scoreboard sb;
    int              send_idle_pct;
    int              stall_pct;

    alert_pulse_pattern_gen_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
        if (result_valid && result_ready)
            sb.check_result(result);
    end

    task automatic send_query(input logic [2:0] src, input logic [31:0] t);
        query_t q;
        q.source  = src;
        q.time_ms = t;
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        query       <= q;
        @(posedge clk);
        while (!query_ready)
            @(posedge clk);
        sb.note_query(q);
    endtask

    // aims the time near a pulse window edge, otherwise anywhere in the 32-bit range or at 0 to 7100
    task automatic send_random_query();
        longint unsigned led_len, vib_len, period, count, pause, plen, k, t, edge_at;
        int              src;
        int              pick;
        int              off;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            src = $urandom_range(5);
            void'(sb.script_row(src, led_len, vib_len, period, count, pause));
            plen = period * count + pause;
            k    = $urandom_range(32'hFFFF_FFFF / plen - 2);
            edge_at = $urandom_range(count - 1) * period + 100;
            case ($urandom_range(2))
                0: edge_at = edge_at;
                1: edge_at = edge_at + led_len;
                default: edge_at = edge_at + vib_len;
            endcase
            off = int'($urandom_range(4)) - 2;
            t   = k * plen + edge_at + longint'(off);
            send_query(src[2:0], t[31:0]);
        end
        else if (pick < 90)
            send_query(3'($urandom_range(7)), $urandom);
        else
            send_query(3'($urandom_range(7)), $urandom_range(7100));
    endtask

    initial
    begin
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        query_valid   = 1'b0;
        query         = '0;
        result_ready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every source, including those with no script row, at time zero
        for (int s = 0; s < 8; s++)
            send_query(s[2:0], 32'd0);
        // first pulse edges of source 0
        send_query(3'd0, 32'd99);
        send_query(3'd0, 32'd100);
        send_query(3'd0, 32'd200);
        send_query(3'd0, 32'd201);
        send_query(3'd0, 32'd299);
        send_query(3'd0, 32'd300);
        // led end is inclusive, vibration end strict with equal lengths
        send_query(3'd1, 32'd600);
        send_query(3'd1, 32'd599);
        // last pulse of source 4
        send_query(3'd4, 32'd3279);
        send_query(3'd4, 32'd3280);
        // one packet later and deep into the time range
        send_query(3'd2, 32'd7120);
        send_query(3'd3, 32'd5751900);
        send_query(3'd5, 32'hFFFF_FFFF);
        send_query(3'd4, 32'hFFFF_FFFF);
        send_query(3'd7, 32'hFFFF_FFFF);
        send_query(3'd6, 32'h8000_0100);
        send_query(3'd3, 32'h7FFF_FFFF);

        send_idle_pct = 27;
        stall_pct     = 51;
        repeat (150) send_random_query();
        send_idle_pct = 51;
        stall_pct     = 27;
        repeat (150) send_random_query();
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (150) send_random_query();
        query_valid <= 1'b0;

        while (sb.expected_pulses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.failures == 0)
            $display("** alert_pulse_pattern_gen_unit: PASSED **");
        else
            $display("** alert_pulse_pattern_gen_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("** alert_pulse_pattern_gen_unit: FAILED **");
        $finish;
    end

endmodule
